/* src/trd_pkg.sv */
// shared types and constants for the row record deserializer
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

  localparam int COL_W            = 5;
  localparam int OUT_COL_W        = 4;
  localparam int NULL_W           = 16;
  localparam int TYPE_W           = 3;
  localparam int TYPES_W          = 48;
  localparam int VALUE_W          = 64;
  localparam int IN_LEN_W         = 20;
  localparam int IN_TDATA_W       = 32;
  localparam int OUT_TDATA_W      = 72;
  localparam int APB_ADDR_W       = 4;
  localparam int APB_DATA_W       = 64;

  localparam int DEF_MAX_COLUMNS  = 16;
  localparam int DEF_LENGTH_WIDTH = 20;
  localparam int DEF_QUEUE_DEPTH  = 4;

  // register select, taken from paddr bit 3
  localparam logic REG_NUM_COLS     = 1'b0;
  localparam logic REG_COLUMN_TYPES = 1'b1;

  // column type codes
  localparam logic [TYPE_W-1:0] TYPE_INVALID = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_BOOL    = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_INT     = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_BIGINT  = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_VARCHAR = 3'd4;

  typedef enum logic [2:0] {
    KIND_NULL    = 3'd0,
    KIND_BOOL    = 3'd1,
    KIND_INT     = 3'd2,
    KIND_BIGINT  = 3'd3,
    KIND_VARLEN  = 3'd4,
    KIND_VARBYTE = 3'd5
  } kind_e;

  // one value result, then nulls for columns null_lo .. null_hi-1
  typedef struct packed {
    logic               val_vld;
    logic [COL_W-1:0]   val_col;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   null_lo;
    logic [COL_W-1:0]   null_hi;
    logic               last;
  } cmd_t;

endpackage

`default_nettype wire

/* src/tuple_row_deserializer.sv */
// top level of the row record deserializer with its register port
//
//   channel  dir  handshake                    words
//   s_axis   in   tvalid/tready                one record byte per word
//   m_axis   out  tvalid/tready                one column result per word
//   apb      in   psel/penable, pready high    column count at 0x0, column types at 0x8
//
// one record byte per cycle unless the queue is full; results are registered
// a byte may expand to up to 16 results (null runs), drained one per unstalled cycle
//   from a QUEUE_DEPTH command queue; s_axis_tready drops only when it is full
// m_axis output register lets a new byte in while a result waits
// reset is asynchronous and leaves the block idle, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module tuple_row_deserializer #(
  parameter int MAX_COLUMNS  = trd_pkg::DEF_MAX_COLUMNS,
  parameter int LENGTH_WIDTH = trd_pkg::DEF_LENGTH_WIDTH,
  parameter int QUEUE_DEPTH  = trd_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // data_byte [7:0], record_length [27:8], zero [31:28]
  input  wire logic [trd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // start_of_record [0]
  input  wire logic                            s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // column_index [3:0], value [67:4], zero [71:68]
  output      logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // kind [2:0]
  output      logic [2:0]                      m_axis_tuser,
  output      logic                            m_axis_tlast,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [trd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [trd_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [trd_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                            pready
);
  import trd_pkg::*;

  logic [COL_W-1:0]     count_q;
  logic [TYPES_W-1:0]   types_q;
  logic                 cfg_wr;

  logic                 push, q_ready, q_valid, q_pop;
  cmd_t                 push_cmd, head_cmd;
  logic [OUT_COL_W-1:0] out_col;
  kind_e                out_kind;
  logic [VALUE_W-1:0]   out_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      types_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_NUM_COLS:     count_q <= pwdata[COL_W-1:0];
        REG_COLUMN_TYPES: types_q <= pwdata[TYPES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_NUM_COLS:     prdata = APB_DATA_W'(count_q);
      REG_COLUMN_TYPES: prdata = APB_DATA_W'(types_q);
      default:          prdata = '0;
    endcase
  end

  trd_front #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata[7:0]),
    .record_length_i (s_axis_tdata[8 +: IN_LEN_W]),
    .start_i         (s_axis_tuser),
    .cfg_count_i     (count_q),
    .cfg_types_i     (types_q),
    .q_ready_i       (q_ready),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (head_cmd),
    .pop_i   (q_pop)
  );

  trd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_col_o   (out_col),
    .out_kind_o  (out_kind),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - VALUE_W - OUT_COL_W)'(0), out_value, out_col};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

/* src/trd_front.sv */
// front end: byte parser, null bitmap, field assembly and column search
`timescale 1ns / 1ps
`default_nettype none

module trd_front #(
  parameter int MAX_COLUMNS  = trd_pkg::DEF_MAX_COLUMNS,
  parameter int LENGTH_WIDTH = trd_pkg::DEF_LENGTH_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [trd_pkg::IN_LEN_W-1:0]  record_length_i,
  input  wire logic                          start_i,
  input  wire logic [trd_pkg::COL_W-1:0]     cfg_count_i,
  input  wire logic [trd_pkg::TYPES_W-1:0]   cfg_types_i,
  input  wire logic                          q_ready_i,
  output      logic                          push_o,
  output      trd_pkg::cmd_t                 cmd_o
);
  import trd_pkg::*;

  localparam int NCOL  = (MAX_COLUMNS < NULL_W) ? MAX_COLUMNS : NULL_W;
  localparam int LW    = LENGTH_WIDTH;
  localparam int SUM_W = ((LW > 16) ? LW : 16) + 1;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_BITMAP   = 5'b00010,
    PH_FIELD    = 5'b00100,
    PH_VARLEN   = 5'b01000,
    PH_VARBYTES = 5'b10000
  } phase_e;

  function automatic logic type_ok(input logic [TYPE_W-1:0] t);
    return (t >= TYPE_BOOL) && (t <= TYPE_VARCHAR);
  endfunction

  function automatic logic [3:0] fixed_size(input logic [TYPE_W-1:0] t);
    logic [3:0] sz;
    unique case (t)
      TYPE_BOOL:   sz = 4'd1;
      TYPE_INT:    sz = 4'd4;
      TYPE_BIGINT: sz = 4'd8;
      default:     sz = 4'd2;
    endcase
    return sz;
  endfunction

  phase_e              phase_q, phase_d;
  logic [LW-1:0]       pos_q, pos_d;
  logic [LW-1:0]       len_q, len_d;
  logic [COL_W-1:0]    cur_q, cur_d;
  logic [55:0]         acc_q, acc_d;
  logic [15:0]         left_q, left_d;
  logic [NULL_W-1:0]   null_q, null_d;
  logic [COL_W-1:0]    cols_q, cols_d;
  logic [TYPES_W-1:0]  types_q, types_d;
  logic [TYPE_W-1:0]   ftype_q, ftype_d;

  logic                accept;
  logic [COL_W-1:0]    cols_smp;
  logic [LW-1:0]       len_smp;
  logic [1:0]          bb_smp;
  logic                short_rec;

  phase_e              e_phase;
  logic [LW-1:0]       e_pos, e_len, pos_n;
  logic [COL_W-1:0]    e_cur, e_cols;
  logic [NULL_W-1:0]   e_null, null_upd;
  logic [TYPES_W-1:0]  e_types;
  logic [1:0]          bb_e;

  logic [VALUE_W-1:0]  full;
  logic [15:0]         slen;
  logic                slen_fits;

  logic [COL_W-1:0]    adv_cur, adv_sel, adv_end;
  logic [TYPE_W-1:0]   adv_type;
  logic [3:0]          adv_size;
  logic                adv_found, adv_fits, adv_go;

  logic                do_adv, cmd_push;
  cmd_t                cmd;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign cols_smp  = (cfg_count_i > COL_W'(NCOL)) ? COL_W'(NCOL) : cfg_count_i;
  assign len_smp   = LW'(record_length_i);
  assign bb_smp    = (cols_smp > COL_W'(8)) ? 2'd2 : 2'd1;
  assign short_rec = start_i && ((cols_smp == '0) || (len_smp < LW'(bb_smp)));

  // a start word loads the record context, then is parsed as bitmap byte 0
  always_comb begin
    if (start_i) begin
      e_phase = PH_BITMAP;
      e_pos   = '0;
      e_len   = len_smp;
      e_cur   = '0;
      e_null  = '0;
      e_cols  = cols_smp;
      e_types = cfg_types_i;
    end else begin
      e_phase = phase_q;
      e_pos   = pos_q;
      e_len   = len_q;
      e_cur   = cur_q;
      e_null  = null_q;
      e_cols  = cols_q;
      e_types = types_q;
    end
  end

  assign pos_n = e_pos + LW'(1);
  assign bb_e  = (e_cols > COL_W'(8)) ? 2'd2 : 2'd1;

  always_comb begin
    null_upd = e_null;
    if (e_phase == PH_BITMAP) begin
      if (e_pos == LW'(0)) begin
        null_upd = e_null | NULL_W'(data_byte_i);
      end else if (e_pos == LW'(1)) begin
        null_upd = e_null | {data_byte_i, 8'h00};
      end
    end
  end

  assign full      = {data_byte_i, acc_q};
  assign slen      = full[63:48];
  assign slen_fits = (SUM_W'(pos_n) + SUM_W'(slen)) <= SUM_W'(e_len);

  // next column that needs record bytes
  assign adv_cur = (e_phase == PH_BITMAP) ? e_cur : COL_W'(e_cur + 1'b1);

  always_comb begin
    adv_found = 1'b0;
    adv_sel   = '0;
    adv_type  = TYPE_INVALID;
    for (int i = 0; i < NCOL; i++) begin
      if (!adv_found && (COL_W'(i) >= adv_cur) && (COL_W'(i) < e_cols) && !null_upd[i]
          && type_ok(e_types[TYPE_W*i +: TYPE_W])) begin
        adv_found = 1'b1;
        adv_sel   = COL_W'(i);
        adv_type  = e_types[TYPE_W*i +: TYPE_W];
      end
    end
  end

  assign adv_size = fixed_size(adv_type);
  assign adv_fits = (SUM_W'(pos_n) + SUM_W'(adv_size)) <= SUM_W'(e_len);
  assign adv_go   = adv_found && adv_fits;
  assign adv_end  = adv_go ? adv_sel : e_cols;

  always_comb begin
    phase_d = e_phase;
    pos_d   = e_pos;
    len_d   = e_len;
    cur_d   = e_cur;
    null_d  = e_null;
    cols_d  = e_cols;
    types_d = e_types;
    acc_d   = acc_q;
    left_d  = left_q;
    ftype_d = ftype_q;
    do_adv  = 1'b0;
    cmd     = '0;

    if (short_rec) begin
      phase_d     = PH_IDLE;
      cmd.null_lo = '0;
      cmd.null_hi = cols_smp;
      cmd.last    = 1'b1;
    end else if (e_phase == PH_IDLE) begin
      phase_d = PH_IDLE;
    end else if (e_pos >= e_len) begin
      phase_d = PH_IDLE;
    end else begin
      pos_d = pos_n;
      unique case (e_phase)
        PH_BITMAP: begin
          null_d = null_upd;
          if (pos_n >= LW'(bb_e)) begin
            do_adv = 1'b1;
          end
        end
        PH_FIELD, PH_VARLEN: begin
          acc_d  = full[63:8];
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            if (e_phase == PH_VARLEN) begin
              if (!slen_fits) begin
                phase_d     = PH_IDLE;
                cmd.null_lo = e_cur;
                cmd.null_hi = e_cols;
                cmd.last    = 1'b1;
              end else begin
                cmd.val_vld = 1'b1;
                cmd.val_col = e_cur;
                cmd.kind    = KIND_VARLEN;
                cmd.value   = VALUE_W'(slen);
                if (slen == 16'd0) begin
                  do_adv = 1'b1;
                end else begin
                  left_d  = slen;
                  phase_d = PH_VARBYTES;
                end
              end
            end else begin
              cmd.val_vld = 1'b1;
              cmd.val_col = e_cur;
              unique case (ftype_q)
                TYPE_BOOL: begin
                  cmd.kind  = KIND_BOOL;
                  cmd.value = VALUE_W'(full[63:56] != 8'h00);
                end
                TYPE_INT: begin
                  cmd.kind  = KIND_INT;
                  cmd.value = {{32{full[63]}}, full[63:32]};
                end
                default: begin
                  cmd.kind  = KIND_BIGINT;
                  cmd.value = full;
                end
              endcase
              do_adv = 1'b1;
            end
          end
        end
        PH_VARBYTES: begin
          cmd.val_vld = 1'b1;
          cmd.val_col = e_cur;
          cmd.kind    = KIND_VARBYTE;
          cmd.value   = VALUE_W'(data_byte_i);
          left_d      = left_q - 16'd1;
          if (left_q <= 16'd1) begin
            do_adv = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (do_adv) begin
      cmd.null_lo = adv_cur;
      cmd.null_hi = adv_end;
      cmd.last    = !adv_go;
      cur_d       = adv_end;
      left_d      = 16'(adv_size);
      ftype_d     = adv_type;
      acc_d       = '0;
      if (!adv_go) begin
        phase_d = PH_IDLE;
      end else if (adv_type == TYPE_VARCHAR) begin
        phase_d = PH_VARLEN;
      end else begin
        phase_d = PH_FIELD;
      end
    end
  end

  assign cmd_push = cmd.val_vld || (cmd.null_lo < cmd.null_hi);
  assign push_o   = accept && cmd_push;
  assign cmd_o    = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      len_q   <= '0;
      cur_q   <= '0;
      left_q  <= '0;
      null_q  <= '0;
      cols_q  <= '0;
      types_q <= '0;
      ftype_q <= TYPE_INVALID;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      null_q  <= null_d;
      cols_q  <= cols_d;
      types_q <= types_d;
      ftype_q <= ftype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

/* src/trd_queue.sv */
// command queue between the parser and the result sequencer
`timescale 1ns / 1ps
`default_nettype none

module trd_queue #(
  parameter int DEPTH = trd_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input       trd_pkg::cmd_t data_i,
  output      logic          ready_o,
  output      logic          valid_o,
  output      trd_pkg::cmd_t data_o,
  input  wire logic          pop_i
);
  import trd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* src/trd_back.sv */
// back end: expands queued commands into results, one per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module trd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input       trd_pkg::cmd_t                 q_cmd_i,
  output      logic                          q_pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [trd_pkg::OUT_COL_W-1:0] out_col_o,
  output      trd_pkg::kind_e                out_kind_o,
  output      logic [trd_pkg::VALUE_W-1:0]   out_value_o,
  output      logic                          out_last_o
);
  import trd_pkg::*;

  logic                 val_done_q, val_done_d;
  logic                 nstart_q, nstart_d;
  logic [COL_W-1:0]     ncol_q, ncol_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_COL_W-1:0] out_col_q;
  kind_e                out_kind_q;
  logic [VALUE_W-1:0]   out_value_q;
  logic                 out_last_q;

  logic                 load_ok, step, emit_val, final_res;
  logic [COL_W-1:0]     null_col, null_next;
  logic [OUT_COL_W-1:0] res_col;
  kind_e                res_kind;
  logic [VALUE_W-1:0]   res_value;

  assign load_ok   = !out_valid_q || out_ready_i;
  assign step      = q_valid_i && load_ok;
  assign emit_val  = q_cmd_i.val_vld && !val_done_q;
  assign null_col  = nstart_q ? ncol_q : q_cmd_i.null_lo;
  assign null_next = COL_W'(null_col + 1'b1);

  always_comb begin
    if (emit_val) begin
      res_col   = OUT_COL_W'(q_cmd_i.val_col);
      res_kind  = q_cmd_i.kind;
      res_value = q_cmd_i.value;
      final_res = !(q_cmd_i.null_lo < q_cmd_i.null_hi);
    end else begin
      res_col   = OUT_COL_W'(null_col);
      res_kind  = KIND_NULL;
      res_value = '0;
      final_res = (null_next >= q_cmd_i.null_hi);
    end
  end

  assign q_pop_o = step && final_res;

  always_comb begin
    val_done_d  = val_done_q;
    nstart_d    = nstart_q;
    ncol_d      = ncol_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      out_valid_d = 1'b1;
      if (final_res) begin
        val_done_d = 1'b0;
        nstart_d   = 1'b0;
      end else if (emit_val) begin
        val_done_d = 1'b1;
      end else begin
        nstart_d = 1'b1;
        ncol_d   = null_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_done_q  <= 1'b0;
      nstart_q    <= 1'b0;
      ncol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      val_done_q  <= val_done_d;
      nstart_q    <= nstart_d;
      ncol_q      <= ncol_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_col_q   <= res_col;
      out_kind_q  <= res_kind;
      out_value_q <= res_value;
      out_last_q  <= final_res && q_cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* src/trd_checker.sv */
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module trd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [2:0]                      m_axis_tuser,
  input wire logic                            m_axis_tlast
);
  import trd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_NULL) |-> (m_axis_tdata[67:4] == '0))
    else $error("null result with nonzero value");

  a_bool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_BOOL) |-> (m_axis_tdata[67:5] == '0))
    else $error("boolean result not 0 or 1");

  a_int_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_INT) |->
      (m_axis_tdata[67:36] == {32{m_axis_tdata[35]}}))
    else $error("integer result not sign extended");

endmodule

bind tuple_row_deserializer trd_checker u_trd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/row_result_checker.sv */
// checker for the row record deserializer: predicts column results and compares them
`timescale 1ns / 1ps

module row_result_checker
  import trd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [IN_TDATA_W-1:0]   s_tdata_i,
  input  logic                    s_tuser_i,
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [OUT_TDATA_W-1:0]  m_tdata_i,
  input  logic [2:0]              m_tuser_i,
  input  logic                    m_tlast_i,
  input  logic                    psel_i,
  input  logic                    penable_i,
  input  logic                    pwrite_i,
  input  logic                    pready_i,
  input  logic [APB_ADDR_W-1:0]   paddr_i,
  input  logic [APB_DATA_W-1:0]   pwdata_i,
  output int                      fail_count_o = 0,
  output int                      pending_o = 0
);

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_BITMAP,
    DEC_FIELD,
    DEC_VARLEN,
    DEC_VARBYTES
  } dec_phase_e;

  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    kind_e                kind;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } row_result_t;

  row_result_t        due_results[$];
  row_result_t        want;
  int                 fails = 0;
  int                 step_hits = 0;

  logic [COL_W-1:0]   cfg_count = '0;
  logic [TYPES_W-1:0] cfg_types = '0;

  logic [COL_W-1:0]   rec_cols = '0;
  logic [TYPES_W-1:0] rec_types = '0;
  logic [NULL_W-1:0]  nulls = '0;
  logic [19:0]        pos = '0;
  logic [19:0]        rec_len = '0;
  logic [COL_W-1:0]   col = '0;
  logic [VALUE_W-1:0] acc = '0;
  logic [15:0]        bytes_left = '0;
  dec_phase_e         dec_phase = DEC_IDLE;

  function automatic logic [TYPE_W-1:0] column_type(logic [COL_W-1:0] c);
    logic [TYPE_W-1:0] t;
    t = rec_types[3*c[3:0] +: 3];
    return (t >= TYPE_BOOL && t <= TYPE_VARCHAR) ? t : TYPE_INVALID;
  endfunction

  function automatic int unsigned field_size(logic [TYPE_W-1:0] t);
    case (t)
      TYPE_BOOL:   return 1;
      TYPE_INT:    return 4;
      TYPE_BIGINT: return 8;
      default:     return 2;
    endcase
  endfunction

  function automatic void put_result(kind_e k, logic [VALUE_W-1:0] v);
    row_result_t r;
    r.col   = col[OUT_COL_W-1:0];
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    due_results.insert(due_results.size(), r);
    step_hits++;
  endfunction

  function automatic void close_row();
    row_result_t r;
    dec_phase = DEC_IDLE;
    if (step_hits > 0) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.insert(due_results.size(), r);
    end
  endfunction

  function automatic void null_remaining();
    while (col < rec_cols) begin
      put_result(KIND_NULL, '0);
      col++;
    end
    close_row();
  endfunction

  // resolve columns needing no bytes, stop at the next one that does, or null the rest if it does not fit
  function automatic void next_column();
    logic [TYPE_W-1:0] t;
    int unsigned       sz;
    bit                done;
    done = 1'b0;
    while (!done && col < rec_cols) begin
      t = column_type(col);
      if (nulls[col[3:0]] || t == TYPE_INVALID) begin
        put_result(KIND_NULL, '0);
        col++;
      end else begin
        sz = field_size(t);
        if (32'(pos) + sz > 32'(rec_len)) begin
          null_remaining();
        end else begin
          acc        = '0;
          bytes_left = 16'(sz);
          dec_phase  = (t == TYPE_VARCHAR) ? DEC_VARLEN : DEC_FIELD;
        end
        done = 1'b1;
      end
    end
    if (!done) close_row();
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [TYPE_W-1:0] t;
    int unsigned       sz;
    logic [15:0]       slen;
    if (dec_phase == DEC_IDLE) return;
    if (pos >= rec_len) begin
      dec_phase = DEC_IDLE;
      return;
    end
    pos++;
    case (dec_phase)
      DEC_BITMAP: begin
        if (pos <= 2) nulls |= 16'(b) << (8 * (32'(pos) - 1));
        if (32'(pos) >= (32'(rec_cols) + 7) / 8) next_column();
      end
      DEC_FIELD, DEC_VARLEN: begin
        t  = column_type(col);
        sz = field_size(t);
        if (bytes_left == 0 || 32'(bytes_left) > sz) begin
          dec_phase = DEC_IDLE;
        end else begin
          acc |= 64'(b) << (8 * (sz - 32'(bytes_left)));
          bytes_left--;
          if (bytes_left == 0) begin
            if (dec_phase == DEC_VARLEN) begin
              slen = acc[15:0];
              if (32'(pos) + 32'(slen) > 32'(rec_len)) begin
                null_remaining();
              end else begin
                put_result(KIND_VARLEN, 64'(slen));
                if (slen == 0) begin
                  col++;
                  next_column();
                end else begin
                  bytes_left = slen;
                  dec_phase  = DEC_VARBYTES;
                end
              end
            end else begin
              case (t)
                TYPE_BOOL: put_result(KIND_BOOL, (acc != 0) ? 64'd1 : 64'd0);
                TYPE_INT:  put_result(KIND_INT, {{32{acc[31]}}, acc[31:0]});
                default:   put_result(KIND_BIGINT, acc);
              endcase
              col++;
              next_column();
            end
          end
        end
      end
      DEC_VARBYTES: begin
        put_result(KIND_VARBYTE, 64'(b));
        if (bytes_left > 0) bytes_left--;
        if (bytes_left == 0) begin
          col++;
          next_column();
        end
      end
      default: dec_phase = DEC_IDLE;
    endcase
  endfunction

  function automatic void decode_record_word(logic [7:0] b, logic [19:0] len, logic first);
    step_hits = 0;
    if (first) begin
      rec_cols   = (cfg_count > 5'(DEF_MAX_COLUMNS)) ? 5'(DEF_MAX_COLUMNS) : cfg_count;
      rec_types  = cfg_types;
      rec_len    = len;
      nulls      = '0;
      pos        = '0;
      col        = '0;
      acc        = '0;
      bytes_left = '0;
      dec_phase  = DEC_IDLE;
      if (rec_cols != 0) begin
        if (32'(rec_len) < (32'(rec_cols) + 7) / 8) begin
          null_remaining();
        end else begin
          dec_phase = DEC_BITMAP;
          take_byte(b);
        end
      end
    end else begin
      take_byte(b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count  = '0;
      cfg_types  = '0;
      rec_cols   = '0;
      rec_types  = '0;
      nulls      = '0;
      pos        = '0;
      rec_len    = '0;
      col        = '0;
      acc        = '0;
      bytes_left = '0;
      dec_phase  = DEC_IDLE;
      due_results.delete();
      fails      = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[3] == REG_COLUMN_TYPES) cfg_types = pwdata_i[TYPES_W-1:0];
        else cfg_count = pwdata_i[COL_W-1:0];
      end
      if (s_tvalid_i && s_tready_i)
        decode_record_word(s_tdata_i[7:0], s_tdata_i[27:8], s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word col %0d kind %0d value %0h last %0b", $time,
                   m_tdata_i[3:0], m_tuser_i, m_tdata_i[67:4], m_tlast_i);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (m_tdata_i[3:0] != want.col) begin
            $display("%0t: column_index expected %0d actual %0d", $time, want.col,
                     m_tdata_i[3:0]);
            fails++;
          end
          if (m_tuser_i != want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_tuser_i);
            fails++;
          end
          if (m_tdata_i[67:4] != want.value) begin
            $display("%0t: value expected %0h actual %0h", $time, want.value,
                     m_tdata_i[67:4]);
            fails++;
          end
          if (m_tlast_i != want.last) begin
            $display("%0t: last_of_row expected %0b actual %0b", $time, want.last,
                     m_tlast_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_results.size();
  end

endmodule

/* tb/tb.sv */
// testbench top for the row record deserializer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import trd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_WORDS = 28;
  localparam int SETTLE_CYCLES = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   s_user = 1'b0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [2:0]             m_user;
  logic                   m_last;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int                     fail_count;
  int                     pending;
  int                     words_sent = 0;
  bit                     no_idle = 1'b0;
  bit                     hold_req = 1'b0;
  logic [COL_W-1:0]       cfg_count = '0;
  logic [TYPES_W-1:0]     cfg_types = '0;

  always #6 clk = ~clk;

  tuple_row_deserializer u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  row_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tuser_i    (m_user),
    .m_tlast_i    (m_last),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_word(input logic [7:0] b, input logic [19:0] len, input logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0, len, b};
    s_user  <= first;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_record(ref logic [7:0] rec[$], input logic [19:0] len, input int count);
    int i;
    if (count == 0) begin
      send_word(8'($urandom), len, 1'b1);
    end else begin
      for (i = 0; i < count; i++)
        send_word(rec[i], (i == 0) ? len : 20'($urandom), i == 0);
    end
  endtask

  task automatic apb_write(input logic regsel, input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_schema(input logic [COL_W-1:0] count, input logic [TYPES_W-1:0] types);
    apb_write(REG_NUM_COLS, {32'($urandom), 27'($urandom), count});
    apb_write(REG_COLUMN_TYPES, {16'($urandom), types});
    cfg_count = count;
    cfg_types = types;
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TYPES_W-1:0] mixed_types();
    logic [TYPES_W-1:0] t;
    int c;
    for (c = 0; c < 16; c++)
      t[3*c +: 3] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
    return t;
  endfunction

  // well-formed record for the current schema, then a length that may cut it short
  task automatic make_record(ref logic [7:0] rec[$], output logic [19:0] len);
    int c, i, slen, total, mode, n;
    logic [15:0] null_bits;
    logic [7:0] bm;
    logic [TYPE_W-1:0] t;
    rec.delete();
    null_bits = '0;
    n = (cfg_count > 16) ? 16 : cfg_count;
    for (i = 0; i < (n + 7) / 8; i++) begin
      bm = 8'($urandom & $urandom);
      null_bits[8*i +: 8] = bm;
      rec.insert(rec.size(), bm);
    end
    for (c = 0; c < n; c++) begin
      t = cfg_types[3*c +: 3];
      if (!null_bits[c]) begin
        case (t)
          TYPE_BOOL:   rec.insert(rec.size(),
                                  ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
          TYPE_INT:    repeat (4) rec.insert(rec.size(), 8'($urandom));
          TYPE_BIGINT: repeat (8) rec.insert(rec.size(), 8'($urandom));
          TYPE_VARCHAR: begin
            slen = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
            rec.insert(rec.size(), 8'(slen));
            rec.insert(rec.size(), 8'(slen >> 8));
            repeat (slen) rec.insert(rec.size(), 8'($urandom));
          end
          default: ;
        endcase
      end
    end
    total = rec.size();
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      len = 20'(total);
    end else if (mode < 75) begin
      len = 20'(total);
      repeat ($urandom_range(1, 3)) rec.insert(rec.size(), 8'($urandom));
    end else if (mode < 88) begin
      len = 20'($urandom_range(0, total));
    end else begin
      len = 20'($urandom);
      if (len < total) len = 20'(total);
    end
  endtask

  initial begin : receiver
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] rec[$];
    logic [19:0] len;
    logic [COL_W-1:0] new_count;
    logic [TYPES_W-1:0] new_types;
    int p, phase_start, k;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // zero columns straight after reset
    rec.delete();
    send_record(rec, 20'd5, 0);
    wait_idle();

    write_schema(5'd4, 48'({TYPE_VARCHAR, TYPE_BIGINT, TYPE_INT, TYPE_BOOL}));
    rec = '{8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff,
            8'hff, 8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h5a};
    send_record(rec, 20'd17, rec.size());
    // short record
    rec.delete();
    send_record(rec, 20'd0, 0);
    // every column null
    rec = '{8'h0f};
    send_record(rec, 20'd1, 1);
    // stray word with no record open
    send_word(8'ha5, 20'hfffff, 1'b0);
    // bigint runs past the end
    rec = '{8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f};
    send_record(rec, 20'd6, rec.size());
    // empty string
    rec = '{8'h07, 8'h00, 8'h00};
    send_record(rec, 20'd3, rec.size());
    // string runs past the end
    rec = '{8'h07, 8'h05, 8'h00, 8'h41};
    send_record(rec, 20'd4, rec.size());

    for (p = 1; p <= 10; p++) begin
      case (p)
        1: begin new_count = 5'd16; new_types = mixed_types(); end
        2: begin new_count = 5'd31; new_types = '1; end
        3: begin new_count = 5'd1; new_types = {16'($urandom), 32'($urandom)}; end
        4: begin new_count = 5'd9; new_types = mixed_types(); end
        5: begin new_count = 5'd0; new_types = '0; end
        6: begin new_count = 5'd8; new_types = {16{TYPE_VARCHAR}}; end
        default: begin new_count = 5'($urandom_range(0, 31)); new_types = mixed_types(); end
      endcase
      wait_idle();
      write_schema(new_count, new_types);
      no_idle = (p == 3 || p == 6);
      if (p == 1) hold_req = 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        make_record(rec, len);
        k = rec.size();
        if (k > 1 && $urandom_range(0, 19) == 0) k = $urandom_range(1, k - 1);
        send_record(rec, len, k);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_word(8'($urandom), 20'($urandom), 1'b0);
      end
    end
    no_idle = 1'b0;

    wait_idle();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
